// File: src/rqt_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Retransmit queue timer package
// Shared types, mode codes, register indexes and reset constants.
// ---------------------------------------------------------------------------
package rqt_pkg;

    // Default queue depth
    localparam int QUEUE_DEPTH = 16;

    // Item mode codes (query and unused codes only report)
    localparam logic [2:0] MODE_PUSH = 3'd0;
    localparam logic [2:0] MODE_ACK  = 3'd1;
    localparam logic [2:0] MODE_RETX = 3'd3;
    localparam logic [2:0] MODE_RTO  = 3'd4;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_TO = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_TO = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TO   = 2'd2;

    // Reset values and fixed report constants
    localparam logic [31:0] START_TO_RST    = 32'd1000;
    localparam logic [31:0] RESET_TO_RST    = 32'd1000;
    localparam logic [31:0] MAX_TO_RST      = 32'd60000;
    localparam logic [31:0] EMPTY_TIME_LEFT = 32'd1000;
    localparam logic [15:0] RETRY_MAX       = 16'hFFFF;

    // Input item
    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] seq_start;
        logic [31:0] seq_stop;
        logic [31:0] ack_number;
        logic [31:0] now_ms;
    } t_in;

    // Result item
    typedef struct packed {
        logic        ack_removed;
        logic        push_dropped;
        logic        expired;
        logic        front_valid;
        logic [31:0] front_seq_start;
        logic [31:0] front_seq_stop;
        logic [15:0] front_retries;
        logic [31:0] time_left_ms;
        logic [4:0]  entry_count;
    } t_out;

    // Controller to datapath commands
    typedef struct packed {
        logic load;     // capture the accepted item
        logic exec;     // apply one step of the item's mode
        logic elapse;   // register elapsed time of the front entry
        logic report;   // build and present the result
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic pop;      // ack step in progress will retire the front entry
    } t_sts;

endpackage
`default_nettype wire

// File: src/tcp_retransmit_queue_timer.sv
`default_nettype none
// ---------------------------------------------------------------------------
// TCP retransmit queue timer
// FIFO of unacknowledged segments with a retransmit timer and backoff.
// ---------------------------------------------------------------------------
// Usage:
//   Items are issued on i_start with the payload on i_in; an item is taken
//   at an edge where i_start is high and o_busy is low. Each item yields one
//   result on o_out, marked by o_done for exactly one cycle. The result
//   side has no back-pressure, so the receiver must take every beat.
//   Sequence: after accept the item runs the exec, settle, elapse and
//   report steps; an ack runs exec and settle again for every entry it
//   retires (each pop waits in settle for the registered head read of the
//   entry memory). o_busy drops in the cycle the result is shown, so the
//   next item may start then; no item is taken while one is in progress.
//   Configuration: register index and data on i_cfg_index / i_cfg_data,
//   written when i_cfg_valid and o_cfg_ready are both high; ready is high
//   while no item is in progress. Writing start_timeout also reloads the
//   current timeout.
//   Reset (synchronous, active low) empties the queue, restores the
//   register defaults and loads the current timeout from start_timeout.
// ---------------------------------------------------------------------------
module tcp_retransmit_queue_timer #(
    parameter int QUEUE_DEPTH = rqt_pkg::QUEUE_DEPTH
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    output logic                               o_busy,
    input  wire rqt_pkg::t_in                  i_in,
    output logic                               o_done,
    output rqt_pkg::t_out                      o_out,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [rqt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]                   i_cfg_data
);

    rqt_pkg::t_cmd cmd;
    rqt_pkg::t_sts sts;
    logic          busy;
    logic          cfg_we;

    // Config writes are taken between items
    assign o_cfg_ready = !busy;
    assign cfg_we      = i_cfg_valid && !busy;
    assign o_busy      = busy;

    rqt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    rqt_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_done      (o_done),
        .o_out       (o_out)
    );

endmodule
`default_nettype wire

// File: src/rqt_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Retransmit queue timer controller
// Sequences one item: execute, settle the head read, time and report.
// ---------------------------------------------------------------------------
module rqt_ctrl (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire rqt_pkg::t_sts i_sts,
    output rqt_pkg::t_cmd     o_cmd,
    output logic              o_busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SETTLE,
        S_ELAPSE,
        S_REPORT
    } t_state;

    t_state r_state;
    logic   r_busy;
    logic   r_again;

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_again <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_EXEC;
                        r_busy  <= 1'b1;
                    end
                end
                S_EXEC: begin
                    r_again <= i_sts.pop;
                    r_state <= S_SETTLE;
                end
                S_SETTLE: begin
                    // after a pop the new head must be examined again
                    r_state <= r_again ? S_EXEC : S_ELAPSE;
                end
                S_ELAPSE: begin
                    r_state <= S_REPORT;
                end
                S_REPORT: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    // Commands
    always_comb begin
        o_cmd        = '0;
        o_cmd.load   = (r_state == S_IDLE) && i_start;
        o_cmd.exec   = (r_state == S_EXEC);
        o_cmd.elapse = (r_state == S_ELAPSE);
        o_cmd.report = (r_state == S_REPORT);
    end

    assign o_busy = r_busy;

`ifndef SYNTHESIS
    // busy flag tracks the state machine
    a_busy_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy == (r_state != S_IDLE))
        else $error("busy flag out of step with state");

    // after the elapse step an item always goes on to report, then busy drops
    a_elapse_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.elapse |=> o_cmd.report ##1 !o_busy)
        else $error("elapse not followed by report");

    // a settle without a pending pop leads to timing, not another step
    a_settle_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SETTLE && !r_again) |=> o_cmd.elapse)
        else $error("settle did not move on to elapse");
`endif

endmodule
`default_nettype wire

// File: src/rqt_dp.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Retransmit queue timer datapath
// Entry memory, queue pointers, timeout registers and result register.
// ---------------------------------------------------------------------------
module rqt_dp #(
    parameter int QUEUE_DEPTH = rqt_pkg::QUEUE_DEPTH
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire rqt_pkg::t_in               i_in,
    input  wire rqt_pkg::t_cmd              i_cmd,
    output rqt_pkg::t_sts                   o_sts,
    input  wire logic                       i_cfg_we,
    input  wire logic [rqt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]                i_cfg_data,
    output logic                            o_done,
    output rqt_pkg::t_out                   o_out
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int OW = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [31:0] seq_start;
        logic [31:0] seq_stop;
        logic [31:0] sent_time;
        logic [15:0] retries;
    } t_entry;

    t_entry        r_mem [QUEUE_DEPTH];
    t_entry        r_rdata;
    rqt_pkg::t_in  r_item;
    rqt_pkg::t_out r_out;
    logic          r_done;
    logic [PW-1:0] r_head;
    logic [PW-1:0] r_tail;
    logic [OW-1:0] r_occ;
    logic [31:0]   r_cur_to;
    logic [31:0]   r_start_to;
    logic [31:0]   r_reset_to;
    logic [31:0]   r_max_to;
    logic [31:0]   r_elapsed;
    logic          r_removed;
    logic          r_dropped;

    logic          empty;
    logic          full;
    logic          pop;
    logic          push_ok;
    logic          retx_ok;
    logic          w_en;
    logic [PW-1:0] w_addr;
    t_entry        w_data;
    logic [PW-1:0] head_nx;
    logic [PW-1:0] tail_nx;
    logic [15:0]   retries_inc;
    logic [32:0]   doubled;
    logic [31:0]   backoff;
    logic [32:0]   diff;
    rqt_pkg::t_out n_out;

    // Queue status and step decode
    assign empty   = (r_occ == '0);
    assign full    = (r_occ == OW'(QUEUE_DEPTH));
    assign pop     = (r_item.mode == rqt_pkg::MODE_ACK) && !empty
                     && (r_rdata.seq_stop <= r_item.ack_number);
    assign push_ok = i_cmd.exec && (r_item.mode == rqt_pkg::MODE_PUSH) && !full;
    assign retx_ok = i_cmd.exec && (r_item.mode == rqt_pkg::MODE_RETX) && !empty;
    assign o_sts.pop = pop;

    assign head_nx = (r_head == PW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign tail_nx = (r_tail == PW'(QUEUE_DEPTH - 1)) ? '0 : r_tail + 1'b1;

    // Retransmit stamp and backoff
    assign retries_inc = (r_rdata.retries == rqt_pkg::RETRY_MAX) ?
                         r_rdata.retries : r_rdata.retries + 16'd1;
    assign doubled = {r_cur_to, 1'b0};
    assign backoff = (doubled > {1'b0, r_max_to}) ? r_max_to : doubled[31:0];

    // Memory write port: new tail on push, restamped head on retransmit
    always_comb begin
        w_en   = push_ok || retx_ok;
        w_addr = push_ok ? r_tail : r_head;
        if (push_ok) begin
            w_data = '{seq_start: r_item.seq_start, seq_stop: r_item.seq_stop,
                       sent_time: r_item.now_ms, retries: 16'd0};
        end else begin
            w_data = '{seq_start: r_rdata.seq_start, seq_stop: r_rdata.seq_stop,
                       sent_time: r_item.now_ms, retries: retries_inc};
        end
    end

    // Entry memory; the head entry is read every cycle
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_addr] <= w_data;
        end
        r_rdata <= r_mem[r_head];
    end

    // Item capture and timing payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in;
        end
        if (i_cmd.elapse) begin
            r_elapsed <= r_item.now_ms - r_rdata.sent_time;
        end
        if (i_cmd.report) begin
            r_out <= n_out;
        end
    end

    // Queue pointers, flags, timeout and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_tail     <= '0;
            r_occ      <= '0;
            r_removed  <= 1'b0;
            r_dropped  <= 1'b0;
            r_done     <= 1'b0;
            r_start_to <= rqt_pkg::START_TO_RST;
            r_reset_to <= rqt_pkg::RESET_TO_RST;
            r_max_to   <= rqt_pkg::MAX_TO_RST;
            r_cur_to   <= rqt_pkg::START_TO_RST;
        end else begin
            r_done <= i_cmd.report;
            if (i_cmd.load) begin
                r_removed <= 1'b0;
                r_dropped <= 1'b0;
            end
            if (push_ok) begin
                r_tail <= tail_nx;
                r_occ  <= r_occ + 1'b1;
            end
            if (i_cmd.exec && (r_item.mode == rqt_pkg::MODE_PUSH) && full) begin
                r_dropped <= 1'b1;
            end
            if (i_cmd.exec && pop) begin
                r_head    <= head_nx;
                r_occ     <= r_occ - 1'b1;
                r_removed <= 1'b1;
            end
            // timeout: config write of start value, backoff, or restore
            if (i_cfg_we && (i_cfg_index == rqt_pkg::CFG_START_TO)) begin
                r_start_to <= i_cfg_data;
                r_cur_to   <= i_cfg_data;
            end else if (retx_ok) begin
                r_cur_to <= backoff;
            end else if (i_cmd.exec && (r_item.mode == rqt_pkg::MODE_RTO)) begin
                r_cur_to <= r_reset_to;
            end
            if (i_cfg_we && (i_cfg_index == rqt_pkg::CFG_RESET_TO)) begin
                r_reset_to <= i_cfg_data;
            end
            if (i_cfg_we && (i_cfg_index == rqt_pkg::CFG_MAX_TO)) begin
                r_max_to <= i_cfg_data;
            end
        end
    end

    // Report: expired when elapsed reaches the timeout
    assign diff = {1'b0, r_cur_to} - {1'b0, r_elapsed};

    always_comb begin
        n_out              = '0;
        n_out.ack_removed  = r_removed;
        n_out.push_dropped = r_dropped;
        n_out.entry_count  = 5'(r_occ);
        n_out.time_left_ms = rqt_pkg::EMPTY_TIME_LEFT;
        if (!empty) begin
            n_out.front_valid     = 1'b1;
            n_out.front_seq_start = r_rdata.seq_start;
            n_out.front_seq_stop  = r_rdata.seq_stop;
            n_out.front_retries   = r_rdata.retries;
            if (diff[32] || (diff[31:0] == 32'd0)) begin
                n_out.expired      = 1'b1;
                n_out.time_left_ms = 32'd0;
            end else begin
                n_out.time_left_ms = diff[31:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_out  = r_out;

`ifndef SYNTHESIS
    // occupancy never exceeds the queue depth
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OW'(QUEUE_DEPTH))
        else $error("queue occupancy above depth");

    // pointers meet only when the queue is empty or full
    a_ptr_meet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head == r_tail) == (empty || full))
        else $error("queue pointers inconsistent with occupancy");

    // result strobe lasts a single cycle
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("result strobe held longer than one cycle");

    // an ack never adds entries (a push never removes any; only the ack side is asserted)
    a_occ_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && (r_item.mode == rqt_pkg::MODE_ACK)) |=> r_occ <= $past(r_occ))
        else $error("ack step grew the queue");
`endif

endmodule
`default_nettype wire

// File: verif/rqt_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Retransmit queue timer checker
// Watches the item, result and register channels of the block. It keeps its
// own copy of the segment queue, the timer registers and the current
// timeout, works out the report for every accepted item, and compares each
// result beat with the oldest report still outstanding, field by field.
// ---------------------------------------------------------------------------
module rqt_checker #(
    parameter int DEPTH = rqt_pkg::QUEUE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_busy,
    input  rqt_pkg::t_in                  i_in,
    input  logic                          i_done,
    input  rqt_pkg::t_out                 i_out,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [rqt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_compared,
    output int                            o_dropped,
    output int                            o_expired
);

    // Shadow of the segment queue
    logic [31:0] seg_start   [DEPTH];
    logic [31:0] seg_stop    [DEPTH];
    logic [31:0] seg_sent    [DEPTH];
    logic [15:0] seg_retries [DEPTH];
    int          head_idx;
    int          tail_idx;
    int          fill;

    // Shadow of the timer registers
    logic [31:0] start_to;
    logic [31:0] reset_to;
    logic [31:0] max_to;
    logic [31:0] cur_to;

    // Reports still owed by the block, oldest first
    rqt_pkg::t_out report_q[$];
    int            n_seen;
    int            n_fail;
    int            n_drop;
    int            n_expire;

    // One line per mismatch
    task automatic report_mismatch(input string msg);
        n_fail++;
        $display("[%0t] mismatch on result beat %0d: %s", $time, n_seen, msg);
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s is %h, expected %h", what, got, want));
        end
    endtask

    task automatic compare_report(input rqt_pkg::t_out got, input rqt_pkg::t_out want);
        check_field("ack_removed", 32'(got.ack_removed), 32'(want.ack_removed));
        check_field("push_dropped", 32'(got.push_dropped), 32'(want.push_dropped));
        check_field("expired", 32'(got.expired), 32'(want.expired));
        check_field("front_valid", 32'(got.front_valid), 32'(want.front_valid));
        check_field("front_seq_start", got.front_seq_start, want.front_seq_start);
        check_field("front_seq_stop", got.front_seq_stop, want.front_seq_stop);
        check_field("front_retries", 32'(got.front_retries), 32'(want.front_retries));
        check_field("time_left_ms", got.time_left_ms, want.time_left_ms);
        check_field("entry_count", 32'(got.entry_count), 32'(want.entry_count));
    endtask

    // Register write; a new start timeout also reloads the running timeout
    task automatic write_register(input logic [rqt_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [31:0] val);
        case (idx)
            rqt_pkg::CFG_START_TO: begin
                start_to = val;
                cur_to   = val;
            end
            rqt_pkg::CFG_RESET_TO: reset_to = val;
            rqt_pkg::CFG_MAX_TO:   max_to   = val;
            default: ;
        endcase
    endtask

    // Apply one event to the shadow queue and build the report it yields
    function automatic rqt_pkg::t_out queue_report(input rqt_pkg::t_in ev);
        rqt_pkg::t_out r;
        logic [31:0]   elapsed;
        logic [32:0]   doubled;
        r = '0;
        case (ev.mode)
            rqt_pkg::MODE_PUSH: begin
                if (fill >= DEPTH) begin
                    r.push_dropped = 1'b1;
                end else begin
                    seg_start[tail_idx]   = ev.seq_start;
                    seg_stop[tail_idx]    = ev.seq_stop;
                    seg_sent[tail_idx]    = ev.now_ms;
                    seg_retries[tail_idx] = '0;
                    tail_idx = (tail_idx + 1) % DEPTH;
                    fill++;
                end
            end
            rqt_pkg::MODE_ACK: begin
                // plain unsigned compare, no sequence-space wrap
                while (fill > 0 && seg_stop[head_idx] <= ev.ack_number) begin
                    head_idx = (head_idx + 1) % DEPTH;
                    fill--;
                    r.ack_removed = 1'b1;
                end
            end
            rqt_pkg::MODE_RETX: begin
                if (fill > 0) begin
                    seg_sent[head_idx] = ev.now_ms;
                    if (seg_retries[head_idx] != rqt_pkg::RETRY_MAX) begin
                        seg_retries[head_idx] = seg_retries[head_idx] + 16'd1;
                    end
                    doubled = {cur_to, 1'b0};
                    cur_to  = (doubled > {1'b0, max_to}) ? max_to : doubled[31:0];
                end
            end
            rqt_pkg::MODE_RTO: cur_to = reset_to;
            default: ;
        endcase

        // front report
        r.time_left_ms = rqt_pkg::EMPTY_TIME_LEFT;
        if (fill > 0) begin
            elapsed           = ev.now_ms - seg_sent[head_idx];
            r.front_valid     = 1'b1;
            r.front_seq_start = seg_start[head_idx];
            r.front_seq_stop  = seg_stop[head_idx];
            r.front_retries   = seg_retries[head_idx];
            if (elapsed >= cur_to) begin
                r.expired      = 1'b1;
                r.time_left_ms = '0;
            end else begin
                r.time_left_ms = cur_to - elapsed;
            end
        end
        r.entry_count = 5'(fill);
        return r;
    endfunction

    // Channel monitor: results first, then register writes, then new items
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            head_idx = 0;
            tail_idx = 0;
            fill     = 0;
            start_to = rqt_pkg::START_TO_RST;
            reset_to = rqt_pkg::RESET_TO_RST;
            max_to   = rqt_pkg::MAX_TO_RST;
            cur_to   = rqt_pkg::START_TO_RST;
            report_q.delete();
        end else begin
            if (i_done) begin
                n_seen++;
                if (report_q.size() == 0) begin
                    report_mismatch("result beat with no item outstanding");
                end else begin
                    compare_report(i_out, report_q[0]);
                    report_q.delete(0);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                write_register(i_cfg_index, i_cfg_data);
            end
            if (i_start && !i_busy) begin
                report_q.insert(report_q.size(), queue_report(i_in));
                if (report_q[$].push_dropped) n_drop++;
                if (report_q[$].expired) n_expire++;
            end
        end
        o_fail_count <= n_fail;
        o_pending    <= report_q.size();
        o_compared   <= n_seen;
        o_dropped    <= n_drop;
        o_expired    <= n_expire;
    end

endmodule

// File: verif/tb_tcp_retransmit_queue_timer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Retransmit queue timer testbench
// Feeds the block directed corner cases, then randomized TCP-like sessions
// (pushes with advancing sequence numbers, cumulative acks, retransmits and
// timer resets) mixed with raw random events, under several timer register
// settings, plus a run of repeated retransmits on one segment. The
// checker beside the block predicts and compares every result beat.
// ---------------------------------------------------------------------------
module tb_tcp_retransmit_queue_timer;

    // Modes that only report
    localparam logic [2:0] MODE_QUERY   = 3'd2;
    localparam logic [2:0] MODE_SPARE_5 = 3'd5;
    localparam logic [2:0] MODE_SPARE_6 = 3'd6;
    localparam logic [2:0] MODE_SPARE_7 = 3'd7;
    // Register index with no register behind it
    localparam logic [rqt_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;
    localparam int          RAND_ITEMS = 255;       // per register setting with a random run
    localparam int          SOAK_RETX  = 40;        // backoff runs into the cap

    // Block ports
    logic                          i_clk;
    logic                          i_rst_n     = 1'b0;
    logic                          i_start     = 1'b0;
    rqt_pkg::t_in                  i_in        = '0;
    logic                          i_cfg_valid = 1'b0;
    logic [rqt_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0]                   i_cfg_data  = '0;
    logic                          o_busy;
    logic                          o_done;
    logic                          o_cfg_ready;
    rqt_pkg::t_out                 o_out;

    // Checker status
    int fail_count;
    int pending;
    int compared;
    int dropped_seen;
    int expired_seen;

    // Sender state: sequence cursors and the wall clock in ms
    logic [31:0] snd_nxt;
    logic [31:0] snd_una;
    logic [31:0] clock_ms;
    int          idle_odds;     // 0 means back to back
    int          time_span;     // usual spread of clock steps
    int          mode_tally [8];
    int          n_items;
    int          n_settings;
    int          waited;

    tcp_retransmit_queue_timer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_in        (i_in),
        .o_done      (o_done),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    rqt_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_busy       (o_busy),
        .i_in         (i_in),
        .i_done       (o_done),
        .i_out        (o_out),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_compared   (compared),
        .o_dropped    (dropped_seen),
        .o_expired    (expired_seen)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        #25_000_000;
        $display("timeout: block stopped taking items or returning results");
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic rqt_pkg::t_in make_event(input logic [2:0] mode,
                                                input logic [31:0] s_start,
                                                input logic [31:0] s_stop,
                                                input logic [31:0] ack,
                                                input logic [31:0] now);
        rqt_pkg::t_in ev;
        ev.mode       = mode;
        ev.seq_start  = s_start;
        ev.seq_stop   = s_stop;
        ev.ack_number = ack;
        ev.now_ms     = now;
        return ev;
    endfunction

    // Mostly short clock steps, sometimes long ones, rarely an arbitrary jump
    function automatic logic [31:0] time_step();
        case ($urandom_range(0, 19))
            0:       return $urandom;
            1, 2, 3: return $urandom_range(0, 8 * time_span);
            default: return $urandom_range(0, time_span);
        endcase
    endfunction

    // One item beat, with an optional idle burst in front of it
    task automatic send_item(input rqt_pkg::t_in ev);
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_in    <= ev;
        do @(posedge i_clk); while (o_busy);
        mode_tally[ev.mode]++;
        n_items++;
    endtask

    // Hold off until every outstanding result has come back
    task automatic wait_idle();
        i_start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_reg(input logic [rqt_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // New timer setting, then a full ack to start the session from empty
    task automatic new_setting(input logic [31:0] start_val, input logic [31:0] reset_val,
                               input logic [31:0] max_val, input int span,
                               input logic [31:0] seq_base);
        wait_idle();
        set_reg(rqt_pkg::CFG_START_TO, start_val);
        set_reg(rqt_pkg::CFG_RESET_TO, reset_val);
        set_reg(rqt_pkg::CFG_MAX_TO, max_val);
        n_settings++;
        time_span = span;
        send_item(make_event(rqt_pkg::MODE_ACK, $urandom, $urandom, ALL_ONES, clock_ms));
        snd_nxt = seq_base;
        snd_una = seq_base;
    endtask

    // Well-formed session event; unused fields carry random bits
    task automatic session_item();
        rqt_pkg::t_in ev;
        int           pick;
        pick     = $urandom_range(0, 99);
        clock_ms = clock_ms + time_step();
        ev = make_event(MODE_QUERY, $urandom, $urandom, $urandom, clock_ms);
        if (pick < 40) begin
            ev.mode      = rqt_pkg::MODE_PUSH;
            ev.seq_start = snd_nxt;
            snd_nxt      = snd_nxt + $urandom_range(1, 1460);
            ev.seq_stop  = snd_nxt;
        end else if (pick < 58) begin
            // cumulative ack somewhere in the flight
            ev.mode       = rqt_pkg::MODE_ACK;
            ev.ack_number = snd_una + $urandom_range(0, snd_nxt - snd_una);
            snd_una       = ev.ack_number;
        end else if (pick < 64) begin
            // stale or duplicate ack
            ev.mode       = rqt_pkg::MODE_ACK;
            ev.ack_number = snd_una - $urandom_range(0, 3000);
        end else if (pick < 80) begin
            ev.mode = rqt_pkg::MODE_RETX;
        end else if (pick < 88) begin
            ev.mode = rqt_pkg::MODE_RTO;
        end
        send_item(ev);
    endtask

    // Random items in stretches; each stretch picks its own idle density
    task automatic run_random(input int count, input bit with_idle);
        int done_n;
        int stretch;
        int burst;
        done_n  = 0;
        stretch = 0;
        while (done_n < count) begin
            if (stretch == 0) begin
                stretch   = $urandom_range(20, 60);
                idle_odds = (with_idle && $urandom_range(0, 2) != 0) ? $urandom_range(2, 5) : 0;
            end
            stretch--;
            if ($urandom_range(0, 99) < 4) begin
                // push burst to run the queue into its full state
                burst = $urandom_range(14, 20);
                repeat (burst) begin
                    clock_ms = clock_ms + $urandom_range(0, 20);
                    send_item(make_event(rqt_pkg::MODE_PUSH, snd_nxt, snd_nxt + 32'd536,
                                         $urandom, clock_ms));
                    snd_nxt = snd_nxt + 32'd536;
                end
                done_n += burst;
            end else if ($urandom_range(0, 99) < 15) begin
                // raw noise
                send_item(make_event(3'($urandom_range(0, 7)), $urandom, $urandom, $urandom,
                                     $urandom));
                done_n++;
            end else begin
                session_item();
                done_n++;
            end
        end
    endtask

    // Stimulus
    initial begin
        clock_ms   = '0;
        snd_nxt    = '0;
        snd_una    = '0;
        idle_odds  = 0;
        time_span  = 300;
        n_items    = 0;
        n_settings = 1;
        foreach (mode_tally[m]) mode_tally[m] = 0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty queue, reset register values
        send_item(make_event(MODE_QUERY, '0, '0, '0, '0));
        send_item(make_event(rqt_pkg::MODE_RETX, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES));
        send_item(make_event(rqt_pkg::MODE_ACK, '0, '0, ALL_ONES, 32'd5));
        send_item(make_event(rqt_pkg::MODE_RTO, '0, '0, '0, 32'd10));

        // Fill to the brim; the front two carry extreme sequence values and
        // the front's send time sits just below the clock wrap
        send_item(make_event(rqt_pkg::MODE_PUSH, ALL_ONES, '0, '0, 32'hFFFF_FF00));
        send_item(make_event(rqt_pkg::MODE_PUSH, '0, ALL_ONES, '0, 32'h0000_0010));
        for (int k = 2; k < rqt_pkg::QUEUE_DEPTH; k++) begin
            send_item(make_event(rqt_pkg::MODE_PUSH, k * 100, k * 100 + 100, '0, 32'h20 + k));
        end
        // full queue refuses this one
        send_item(make_event(rqt_pkg::MODE_PUSH, 32'h1234_5678, 32'h1234_9999, '0, 32'h40));

        // Unused modes only report, just short of and then past the timeout; a retransmit follows
        send_item(make_event(MODE_SPARE_5, '0, '0, '0, 32'h0000_0200));
        send_item(make_event(MODE_SPARE_7, ALL_ONES, ALL_ONES, ALL_ONES, 32'h0000_0400));
        send_item(make_event(rqt_pkg::MODE_RETX, '0, '0, '0, 32'h0000_0500));

        // Ack zero retires the zero-stop front; the all-ones stop then blocks
        send_item(make_event(rqt_pkg::MODE_ACK, '0, '0, '0, 32'h0000_0600));
        send_item(make_event(rqt_pkg::MODE_ACK, '0, '0, ALL_ONES - 1, 32'h0000_0700));
        send_item(make_event(rqt_pkg::MODE_ACK, '0, '0, ALL_ONES, 32'h0000_0800));

        // Smallest start timeout, no effective cap: doubling overflows 32 bits
        new_setting(32'd1, ALL_ONES, ALL_ONES, 300, $urandom);
        run_random(RAND_ITEMS, 1'b1);

        // Huge start timeout, smallest reset and cap
        new_setting(ALL_ONES, 32'd1, 32'd1, 300, 32'hFFFF_C000);
        run_random(RAND_ITEMS, 1'b1);

        // Typical values, plus a write to the unused index
        new_setting(32'd200, 32'd350, 32'd6400, 2000, $urandom);
        wait_idle();
        set_reg(CFG_UNUSED, $urandom);
        run_random(RAND_ITEMS / 2, 1'b1);
        wait_idle();
        run_random(RAND_ITEMS - RAND_ITEMS / 2, 1'b1);

        // Random moderate values
        new_setting($urandom_range(1, 5000), $urandom_range(1, 5000),
                    $urandom_range(1, 200000), 3000, $urandom);
        run_random(RAND_ITEMS, 1'b1);

        // Repeated retransmits of a single front segment
        new_setting(rqt_pkg::START_TO_RST, rqt_pkg::RESET_TO_RST, rqt_pkg::MAX_TO_RST, 300,
                    $urandom);
        idle_odds = 0;
        send_item(make_event(rqt_pkg::MODE_PUSH, snd_nxt, snd_nxt + 32'd100, '0, clock_ms));
        for (int k = 0; k < SOAK_RETX; k++) begin
            clock_ms = clock_ms + 32'd1;
            send_item(make_event(rqt_pkg::MODE_RETX, $urandom, $urandom, $urandom, clock_ms));
        end
        send_item(make_event(MODE_QUERY, '0, '0, '0, clock_ms));

        // Closing stretch, back to back
        new_setting($urandom_range(100, 3000), $urandom_range(100, 3000),
                    $urandom_range(3000, 100000), 1000, $urandom);
        run_random(RAND_ITEMS, 1'b0);

        // Drain
        i_start <= 1'b0;
        waited = 0;
        do begin
            @(posedge i_clk);
            waited++;
        end while (pending != 0 && waited < 4000);
        repeat (10) @(posedge i_clk);

        $display("Run covered %0d items: %0d push, %0d ack, %0d retransmit, %0d timer reset,",
                 n_items, mode_tally[rqt_pkg::MODE_PUSH], mode_tally[rqt_pkg::MODE_ACK],
                 mode_tally[rqt_pkg::MODE_RETX], mode_tally[rqt_pkg::MODE_RTO]);
        $display("%0d query or unused; %0d register settings, %0d beats compared, %0d %s",
                 mode_tally[MODE_QUERY] + mode_tally[MODE_SPARE_5] + mode_tally[MODE_SPARE_6]
                 + mode_tally[MODE_SPARE_7],
                 n_settings, compared, dropped_seen,
                 $sformatf("refused pushes, %0d expired fronts", expired_seen));
        if (pending != 0) begin
            $display("%0d results never arrived", pending);
        end
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
src/rqt_pkg.sv
src/rqt_ctrl.sv
src/rqt_dp.sv
src/tcp_retransmit_queue_timer.sv
verif/rqt_checker.sv
verif/tb_tcp_retransmit_queue_timer.sv
